@@ src/gamepad_poll_serial_master_unit_defines.svh @@
// ----------------------------------------------------------------------------
// gamepad poll serial master assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_POLL_SERIAL_MASTER_UNIT_DEFINES_SVH
`define GAMEPAD_POLL_SERIAL_MASTER_UNIT_DEFINES_SVH

// same-cycle implication
`define GPSM_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("gpsm same-cycle check failed");

// next-cycle implication
`define GPSM_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("gpsm next-cycle check failed");

`endif

@@ src/gpsm_pkg.sv @@
// ----------------------------------------------------------------------------
// gpsm_pkg
// types, constants and helpers of the gamepad poll serial master
// ----------------------------------------------------------------------------
package gpsm_pkg;

  localparam int FRAME_LENGTH = 9;
  localparam int BYTE_IDX_W   = $clog2(FRAME_LENGTH);
  localparam int BIT_IDX_W    = 3;
  localparam int HALF_W       = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [7:0]        FRAME_START_BYTE   = 8'h01;
  localparam logic [7:0]        RESET_POLL_COMMAND = 8'h42;
  localparam logic [HALF_W-1:0] RESET_HALF_PERIOD  = 16'd16;

  localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POLL_COMMAND = 2'd1;

  typedef struct packed {
    logic [HALF_W-1:0] half_period_ticks;
    logic [7:0]        poll_command;
  } gpsm_cfg_t;

  typedef struct packed {
    logic       select_n;
    logic       serial_clock;
    logic       command_bit;
    logic       busy_res;
    logic       done_res;
    logic [7:0] pad_mode;
    logic [7:0] buttons_low;
    logic [7:0] buttons_high;
    logic [7:0] right_x;
    logic [7:0] right_y;
    logic [7:0] left_x;
    logic [7:0] left_y;
  } gpsm_result_t;

  function automatic logic [7:0] tx_byte(logic [BYTE_IDX_W-1:0] idx, logic [7:0] poll);
    logic [7:0] b;
    b = 8'h00;
    if (idx == BYTE_IDX_W'(0)) b = FRAME_START_BYTE;
    else if (idx == BYTE_IDX_W'(1)) b = poll;
    return b;
  endfunction

endpackage

@@ src/gpsm_core.sv @@
// ----------------------------------------------------------------------------
// gpsm_core
// frame sequencer: one tick per advance, gives the post-tick pin and data view
// ----------------------------------------------------------------------------
module gpsm_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  start_req,
  input  logic                  data_in,
  input  gpsm_pkg::gpsm_cfg_t    cfg,
  output gpsm_pkg::gpsm_result_t result
);
  import gpsm_pkg::*;

  logic                  active,        active_next;
  logic [HALF_W-1:0]     phase_count,   phase_count_next;
  logic                  clock_level,   clock_level_next;
  logic [BIT_IDX_W-1:0]  bit_index,     bit_index_next;
  logic [BYTE_IDX_W-1:0] byte_index,    byte_index_next;
  logic [7:0]            receive_shift, receive_shift_next;
  logic [7:0]            frame_bytes      [FRAME_LENGTH];
  logic [7:0]            frame_bytes_next [FRAME_LENGTH];
  logic                  done;
  logic [HALF_W-1:0]     half;
  logic [7:0]            cmd_byte;

  always_comb begin
    half = (cfg.half_period_ticks == '0) ? HALF_W'(1) : cfg.half_period_ticks;

    active_next        = active;
    phase_count_next   = phase_count;
    clock_level_next   = clock_level;
    bit_index_next     = bit_index;
    byte_index_next    = byte_index;
    receive_shift_next = receive_shift;
    frame_bytes_next   = frame_bytes;
    done               = 1'b0;

    if (!active) begin
      if (start_req) begin
        active_next        = 1'b1;
        clock_level_next   = 1'b0;
        phase_count_next   = HALF_W'(1);
        bit_index_next     = '0;
        byte_index_next    = '0;
        receive_shift_next = '0;
      end
    end else if (phase_count < half) begin
      phase_count_next = phase_count + HALF_W'(1);
    end else if (!clock_level) begin
      receive_shift_next = receive_shift | (8'(data_in) << bit_index);
      clock_level_next   = 1'b1;
      phase_count_next   = HALF_W'(1);
    end else if (bit_index == BIT_IDX_W'(7)) begin
      if ({1'b0, byte_index} < (BYTE_IDX_W+1)'(FRAME_LENGTH)) begin
        frame_bytes_next[byte_index] = receive_shift;
      end
      receive_shift_next = '0;
      bit_index_next     = '0;
      if ({1'b0, byte_index} + (BYTE_IDX_W+1)'(1) >= (BYTE_IDX_W+1)'(FRAME_LENGTH)) begin
        active_next      = 1'b0;
        byte_index_next  = '0;
        phase_count_next = '0;
        clock_level_next = 1'b1;
        done             = 1'b1;
      end else begin
        byte_index_next  = byte_index + BYTE_IDX_W'(1);
        clock_level_next = 1'b0;
        phase_count_next = HALF_W'(1);
      end
    end else begin
      bit_index_next   = bit_index + BIT_IDX_W'(1);
      clock_level_next = 1'b0;
      phase_count_next = HALF_W'(1);
    end

    cmd_byte = tx_byte(byte_index_next, cfg.poll_command);

    result.select_n     = !active_next;
    result.serial_clock = clock_level_next;
    result.command_bit  = active_next & cmd_byte[bit_index_next];
    result.busy_res     = active_next;
    result.done_res     = done;
    result.pad_mode     = frame_bytes_next[1];
    result.buttons_low  = ~frame_bytes_next[3];
    result.buttons_high = ~frame_bytes_next[4];
    result.right_x      = frame_bytes_next[5];
    result.right_y      = frame_bytes_next[6];
    result.left_x       = frame_bytes_next[7];
    result.left_y       = frame_bytes_next[8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      phase_count   <= '0;
      clock_level   <= 1'b1;
      bit_index     <= '0;
      byte_index    <= '0;
      receive_shift <= '0;
      for (int i = 0; i < FRAME_LENGTH; i++) frame_bytes[i] <= '0;
    end else if (advance) begin
      active        <= active_next;
      phase_count   <= phase_count_next;
      clock_level   <= clock_level_next;
      bit_index     <= bit_index_next;
      byte_index    <= byte_index_next;
      receive_shift <= receive_shift_next;
      frame_bytes   <= frame_bytes_next;
    end
  end

endmodule

@@ src/gamepad_poll_serial_master_unit.sv @@
// ----------------------------------------------------------------------------
// gamepad_poll_serial_master_unit
// gamepad poll master, serial mode 3, lsb first, one tick per transaction
// ----------------------------------------------------------------------------
// Every input transaction is one time tick carrying start_req and the sampled
// data_in pin; the block takes one tick per clock cycle and returns exactly one
// result transaction per tick, the cycle after acceptance, from a single output
// register. The frame sequencer updates in the same cycle the tick is accepted,
// so ticks may arrive back to back; input stall is raised only while the output
// register is full and stalled. A poll frame is 9 bytes, each bit lasting two
// half periods of half_period_ticks ticks (zero counts as one). Configuration
// writes are always ready and should be made while no frame is running.
// ----------------------------------------------------------------------------
`include "gamepad_poll_serial_master_unit_defines.svh"

module gamepad_poll_serial_master_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              start_req,
  input  logic                              data_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              select_n,
  output logic                              serial_clock,
  output logic                              command_bit,
  output logic                              busy_res,
  output logic                              done_res,
  output logic [7:0]                        pad_mode,
  output logic [7:0]                        buttons_low,
  output logic [7:0]                        buttons_high,
  output logic [7:0]                        right_x,
  output logic [7:0]                        right_y,
  output logic [7:0]                        left_x,
  output logic [7:0]                        left_y,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gpsm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [gpsm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gpsm_pkg::*;

  gpsm_cfg_t    cfg;
  gpsm_result_t step_result;
  gpsm_result_t out_reg;
  logic         accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= RESET_HALF_PERIOD;
      cfg.poll_command      <= RESET_POLL_COMMAND;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HALF_PERIOD:  cfg.half_period_ticks <= cfg_data[HALF_W-1:0];
        REG_POLL_COMMAND: cfg.poll_command      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  gpsm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (accept),
    .start_req (start_req),
    .data_in   (data_in),
    .cfg       (cfg),
    .result    (step_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= step_result;
    end
  end

  assign select_n     = out_reg.select_n;
  assign serial_clock = out_reg.serial_clock;
  assign command_bit  = out_reg.command_bit;
  assign busy_res     = out_reg.busy_res;
  assign done_res     = out_reg.done_res;
  assign pad_mode     = out_reg.pad_mode;
  assign buttons_low  = out_reg.buttons_low;
  assign buttons_high = out_reg.buttons_high;
  assign right_x      = out_reg.right_x;
  assign right_y      = out_reg.right_y;
  assign left_x       = out_reg.left_x;
  assign left_y       = out_reg.left_y;

  `GPSM_ASSERT_NEXT(a_accept_gives_result, accept, out_valid)
  `GPSM_ASSERT_NOW(a_done_releases_pins, out_valid && done_res,
                   select_n && serial_clock && !busy_res)
  `GPSM_ASSERT_NOW(a_select_tracks_busy, out_valid, select_n == !busy_res)
  `GPSM_ASSERT_NOW(a_idle_command_low, out_valid && !busy_res, !command_bit)

endmodule
